/* hdl/ksa_pkg.sv */
`default_nettype none
package ksa_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int IN_KEY_W    = 32;
    localparam int SLOT_W      = 7;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;      // compare against incoming key
        logic commit;    // apply the insert shift
        logic in_range;  // cell index below the fill count
    } t_cell_ctl;

    // what a cell hands to its right neighbor
    typedef struct packed {
        logic  lt;
        t_key  key;
        t_slot slot;
    } t_cell_link;

endpackage
`default_nettype wire

/* hdl/ksa_cell.sv */
`default_nettype none
module ksa_cell (
    input  wire                 i_clk,
    input  ksa_pkg::t_cell_ctl  i_ctl,
    input  ksa_pkg::t_key       i_key,
    input  ksa_pkg::t_key       i_new_key,
    input  ksa_pkg::t_slot      i_new_slot,
    input  ksa_pkg::t_cell_link i_prev,
    output ksa_pkg::t_cell_link o_link,
    output logic                o_hit,
    output ksa_pkg::t_slot      o_hit_slot
);

    ksa_pkg::t_key  r_key;
    ksa_pkg::t_slot r_slot;
    logic           r_lt;
    logic           r_hit;
    ksa_pkg::t_slot r_hit_slot;

    logic n_hit;

    assign n_hit = i_ctl.in_range && (r_key == i_key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_lt       <= i_ctl.in_range && (r_key < i_key);
            r_hit      <= n_hit;
            r_hit_slot <= n_hit ? r_slot : '0;
        end
        // cells past the insert point move one place right; the first one takes the new key
        if (i_ctl.commit && !r_lt) begin
            if (i_prev.lt) begin
                r_key  <= i_new_key;
                r_slot <= i_new_slot;
            end else begin
                r_key  <= i_prev.key;
                r_slot <= i_prev.slot;
            end
        end
    end

    assign o_link.lt   = r_lt;
    assign o_link.key  = r_key;
    assign o_link.slot = r_slot;
    assign o_hit       = r_hit;
    assign o_hit_slot  = r_hit_slot;

endmodule
`default_nettype wire

/* hdl/key_dedup_slot_assigner_core.sv */
`default_nettype none
// Key deduplication and slot assignment.
// Input channel: i_valid / o_ready carry one 32-bit i_object_key per word.
// Output channel: o_valid / i_ready carry o_slot_number, o_newly_added and
// o_table_full, one result word for every input word, in order.
// A key already held returns its stored slot. A new key is inserted in
// sorted order into a row of 64 cells and gets slot count+1. With all cells
// in use a new key gets slot 0 and o_table_full, the table is unchanged.
// Timing: the key is compared against every cell in the cycle it is taken;
// in the BUSY state that follows, the cells shift right past the insert point
// and the result is loaded into the output register, once that register is
// free. A new key is not taken until the shift and output load of the key
// before it are done, since o_ready is high only in the idle state.
// While a result waits in the output register a new key can be taken and
// compared; the shift and output load hold until i_ready frees the register.
// Reset (i_rst_n low, synchronous) empties the table and the output; cell
// contents are not cleared, as only cells below the fill count are used.
module key_dedup_slot_assigner_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire [ksa_pkg::IN_KEY_W-1:0] i_object_key,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [ksa_pkg::SLOT_W-1:0]  o_slot_number,
    output logic                        o_newly_added,
    output logic                        o_table_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic           r_state;
    ksa_pkg::t_cnt  r_count;
    ksa_pkg::t_key  r_key;
    logic           r_out_valid;
    ksa_pkg::t_slot r_out_slot;
    logic           r_out_added;
    logic           r_out_full;

    ksa_pkg::t_key  w_key;
    logic           w_accept;
    logic           w_out_free;
    logic           w_finish;
    logic           w_any_hit;
    ksa_pkg::t_slot w_hit_slot;
    logic           w_full;
    logic           w_insert;
    ksa_pkg::t_slot w_new_slot;

    logic           [ksa_pkg::TABLE_DEPTH-1:0] w_hit;
    ksa_pkg::t_slot                            w_cell_slot [ksa_pkg::TABLE_DEPTH];
    ksa_pkg::t_cell_link                       w_link      [ksa_pkg::TABLE_DEPTH+1];
    ksa_pkg::t_cell_ctl                        w_ctl       [ksa_pkg::TABLE_DEPTH];

    assign w_key      = ksa_pkg::KEY_WIDTH'(i_object_key);
    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_finish   = (r_state == ST_BUSY) && w_out_free;

    always_comb begin
        w_hit_slot = '0;
        for (int i = 0; i < ksa_pkg::TABLE_DEPTH; i++) begin
            w_hit_slot = w_hit_slot | w_cell_slot[i];
        end
    end

    assign w_any_hit  = |w_hit;
    assign w_full     = !w_any_hit &&
                        (r_count == ksa_pkg::CNT_W'(ksa_pkg::TABLE_DEPTH));
    assign w_insert   = !w_any_hit && !w_full;
    assign w_new_slot = ksa_pkg::SLOT_W'(r_count + ksa_pkg::CNT_W'(1));

    // left edge of the row: everything before cell 0 counts as smaller
    assign w_link[0].lt   = 1'b1;
    assign w_link[0].key  = '0;
    assign w_link[0].slot = '0;

    for (genvar g = 0; g < ksa_pkg::TABLE_DEPTH; g++) begin : g_cell
        assign w_ctl[g].load     = w_accept;
        assign w_ctl[g].commit   = w_finish && w_insert;
        assign w_ctl[g].in_range = (ksa_pkg::CNT_W'(g) < r_count);

        ksa_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_key      (w_key),
            .i_new_key  (r_key),
            .i_new_slot (w_new_slot),
            .i_prev     (w_link[g]),
            .o_link     (w_link[g+1]),
            .o_hit      (w_hit[g]),
            .o_hit_slot (w_cell_slot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_finish) begin
                r_out_valid <= 1'b1;
                if (w_insert) begin
                    r_count <= r_count + ksa_pkg::CNT_W'(1);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_key;
        end
        if (w_finish) begin
            r_out_slot  <= w_any_hit ? w_hit_slot : (w_insert ? w_new_slot : '0);
            r_out_added <= w_insert;
            r_out_full  <= w_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_slot_number = r_out_slot;
    assign o_newly_added = r_out_added;
    assign o_table_full  = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ksa_pkg::CNT_W'(ksa_pkg::TABLE_DEPTH))
        else $error("fill count above table depth");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUSY) |-> $onehot0(w_hit))
        else $error("key matched in more than one cell");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_newly_added && o_table_full))
        else $error("added and full flagged together");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && w_insert) |=> (r_count == $past(r_count) + ksa_pkg::CNT_W'(1)))
        else $error("fill count did not advance on insert");

endmodule
`default_nettype wire

/* sim/tb_key_dedup_slot_assigner_core.sv */
`default_nettype none
module tb_key_dedup_slot_assigner_core;

    localparam int CLK_HALF     = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_KEYS  = 430;

    typedef struct packed {
        ksa_pkg::t_slot slot;
        logic           added;
        logic           full;
    } t_slot_grant;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic [ksa_pkg::IN_KEY_W-1:0] i_object_key = '0;
    logic                         i_ready      = 1'b0;
    wire                          o_ready;
    wire                          o_valid;
    wire  [ksa_pkg::SLOT_W-1:0]   o_slot_number;
    wire                          o_newly_added;
    wire                          o_table_full;

    key_dedup_slot_assigner_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_object_key  (i_object_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_slot_number (o_slot_number),
        .o_newly_added (o_newly_added),
        .o_table_full  (o_table_full)
    );

    // stimulus bookkeeping
    logic [ksa_pkg::IN_KEY_W-1:0] key_q[$];
    logic [ksa_pkg::IN_KEY_W-1:0] known_keys[$];
    bit                           key_seen[logic [ksa_pkg::IN_KEY_W-1:0]];
    int                           n_stimulus = 0;

    // slot table model, kept sorted by key
    ksa_pkg::t_key  tbl_key [ksa_pkg::TABLE_DEPTH];
    ksa_pkg::t_slot tbl_slot[ksa_pkg::TABLE_DEPTH];
    int             tbl_fill   = 0;
    t_slot_grant    grant_q[$];
    t_slot_grant    want_grant;

    int n_inserted = 0;
    int n_hits     = 0;
    int n_refused  = 0;
    int words_in   = 0;
    int words_out  = 0;
    int errors     = 0;
    int send_gap   = 0;
    int stall_left = 0;
    int quiet      = 0;
    int cycle_n    = 0;
    bit calm       = 1'b0;

    initial forever #CLK_HALF i_clk = ~i_clk;

    function automatic t_slot_grant assign_slot(input logic [ksa_pkg::IN_KEY_W-1:0] raw);
        ksa_pkg::t_key k;
        int            lo;
        int            hi;
        int            mid;
        t_slot_grant   g;
        k  = raw[ksa_pkg::KEY_WIDTH-1:0];
        lo = 0;
        hi = tbl_fill;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_key[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        g = '0;
        if (lo < tbl_fill && tbl_key[lo] == k) begin
            g.slot = tbl_slot[lo];
            n_hits++;
        end else if (tbl_fill >= ksa_pkg::TABLE_DEPTH) begin
            g.full = 1'b1;
            n_refused++;
        end else begin
            for (int i = tbl_fill; i > lo; i--) begin
                tbl_key[i]  = tbl_key[i-1];
                tbl_slot[i] = tbl_slot[i-1];
            end
            tbl_fill++;
            tbl_key[lo]  = k;
            tbl_slot[lo] = ksa_pkg::t_slot'(tbl_fill);
            g.slot       = ksa_pkg::t_slot'(tbl_fill);
            g.added      = 1'b1;
            n_inserted++;
        end
        return g;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    task automatic add_key(input logic [ksa_pkg::IN_KEY_W-1:0] k);
        key_q.push_back(k);
        if (!key_seen.exists(k)) begin
            key_seen[k] = 1'b1;
            known_keys.push_back(k);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d, expected %0d", words_out, what, got, want);
    endtask

    initial begin
        logic [ksa_pkg::IN_KEY_W-1:0] base;
        int                           r;
        // insert at end, front and middle, then hit each end
        add_key(32'h8000_0000); add_key(32'hFFFF_FFFF); add_key(32'h0000_0000);
        add_key(32'h8000_0000); add_key(32'h7FFF_FFFF); add_key(32'h0000_0001);
        add_key(32'hFFFF_FFFE); add_key(32'h0000_0000); add_key(32'hFFFF_FFFF);
        add_key(32'h5555_5555); add_key(32'hAAAA_AAAA); add_key(32'h7FFF_FFFF);
        add_key(32'h8000_0001); add_key(32'h0000_0001);
        // fill to capacity with repeats mixed in, then keep going against a full table
        for (int n = 0; n < RANDOM_KEYS; n++) begin
            r = $urandom_range(0, 99);
            if (r < ((known_keys.size() < ksa_pkg::TABLE_DEPTH) ? 45 : 55)) begin
                add_key(known_keys[$urandom_range(0, known_keys.size() - 1)]);
            end else if (r < 80) begin
                add_key($urandom);
            end else begin
                // near neighbor of a stored key
                base = known_keys[$urandom_range(0, known_keys.size() - 1)];
                add_key($urandom_range(0, 1) ? base + 1'b1 : base - 1'b1);
            end
        end
        n_stimulus = key_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_out < n_stimulus) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (grant_q.size() != 0) report_mismatch("results never delivered", 0, grant_q.size());

        $display("Sent %0d keys: %0d inserted, %0d found again, %0d refused with the table full",
                 words_in, n_inserted, n_hits, n_refused);
        $display("Table ended with %0d of %0d entries; %0d mismatches", tbl_fill,
                 ksa_pkg::TABLE_DEPTH, errors);
        if (errors == 0) begin
            $display("** key_dedup_slot_assigner_core: PASSED **");
        end else begin
            $display("** key_dedup_slot_assigner_core: FAILED **");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            grant_q.push_back(assign_slot(i_object_key));
            words_in++;
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (key_q.size() > 0) begin
                i_valid      <= 1'b1;
                i_object_key <= key_q.pop_front();
                send_gap     = pick_idle();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and output backpressure
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("word with nothing pending, slot", o_slot_number, 0);
            end else begin
                want_grant = grant_q.pop_front();
                if (o_slot_number !== want_grant.slot)
                    report_mismatch("slot_number", o_slot_number, want_grant.slot);
                if (o_newly_added !== want_grant.added)
                    report_mismatch("newly_added", o_newly_added, want_grant.added);
                if (o_table_full !== want_grant.full)
                    report_mismatch("table_full", o_table_full, want_grant.full);
            end
            words_out++;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_idle();
        end
    end

    // watchdog; also switches between calm and gappy stretches
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n % 200 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles (%0d of %0d results seen)",
                     quiet, words_out, n_stimulus);
            $display("** key_dedup_slot_assigner_core: FAILED **");
            $finish;
        end
    end

endmodule
`default_nettype wire

/* sim.f */
hdl/ksa_pkg.sv
hdl/ksa_cell.sv
hdl/key_dedup_slot_assigner_core.sv
sim/tb_key_dedup_slot_assigner_core.sv
